>>> design/sfo_pkg.sv
// Package for the spectral flux onset block: sizes, table generators and shared types.
package sfo_pkg;

  // Transform and storage sizes.
  localparam int unsigned FFT_POINTS = 1024;
  localparam int unsigned LOG_N      = 10;
  localparam int unsigned HALF_N     = FFT_POINTS / 2;
  localparam int unsigned TW_AW      = LOG_N - 1;
  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned RING_AW    = 10;
  localparam int unsigned MAG_BINS   = 256;
  localparam int unsigned BIN_AW     = 8;
  localparam int unsigned STAGE_W    = 4;

  // Datapath widths.
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned DATA_W = 27;
  localparam int unsigned WORD_W = 2 * DATA_W;
  localparam int unsigned PROD_W = 43;
  localparam int unsigned PWR_W  = 40;
  localparam int unsigned FLUX_W = 48;
  localparam int unsigned HOP_W  = 16;

  localparam logic [FLUX_W-1:0] FLUX_MAX  = {FLUX_W{1'b1}};
  localparam logic [HOP_W-1:0]  HOP_RESET = 16'd480;

  // Register map index codes.
  localparam logic REG_HOP_LENGTH = 1'b0;

  // Fixed point angle constants in Q30.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] QUARTER = 64'(FFT_POINTS / 4);
  localparam logic [63:0] EIGHTH  = 64'(FFT_POINTS / 8);
  localparam logic [63:0] NPTS    = 64'(FFT_POINTS);

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } cs_t;

  typedef logic [SMP_W-1:0] hann_rom_t [FFT_POINTS];
  typedef logic [31:0]      tw_rom_t   [HALF_N];

  // Butterfly datapath strobes.
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } bfly_ctrl_t;

  // Cosine and sine in the first octant by truncated Taylor series.
  function automatic cs_t octant_cs(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    cs_t         res;
    x    = (64'd2 * PI_Q30 * r) / NPTS;
    term = x;
    sum  = x;
    for (int n = 1; n <= 4; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    res.s = $signed(sum);
    term  = ONE_Q30;
    sum   = ONE_Q30;
    for (int n = 1; n <= 5; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    res.c = $signed(sum);
    return res;
  endfunction

  // Cosine and sine of a full-circle index, folded from the first octant.
  function automatic cs_t angle_cs(input logic [63:0] k);
    logic [63:0] q;
    logic [63:0] r;
    cs_t         o;
    cs_t         res;
    q = (k / QUARTER) & 64'd3;
    r = k % QUARTER;
    if (r <= EIGHTH) begin
      o = octant_cs(r);
    end else begin
      res = octant_cs(QUARTER - r);
      o.c = res.s;
      o.s = res.c;
    end
    unique case (q[1:0])
      2'd0:    begin res.c = o.c;  res.s = o.s;  end
      2'd1:    begin res.c = -o.s; res.s = o.c;  end
      2'd2:    begin res.c = -o.c; res.s = -o.s; end
      default: begin res.c = o.s;  res.s = -o.c; end
    endcase
    return res;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767)  return 16'h7fff;
    if (v < -64'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic hann_rom_t gen_hann();
    hann_rom_t   t;
    cs_t         cs;
    logic [63:0] w;
    for (int i = 0; i < FFT_POINTS; i++) begin
      cs   = angle_cs(64'(i));
      w    = (ONE_Q30 - $unsigned(cs.c) + 64'd32768) >> 16;
      t[i] = w[15:0];
    end
    return t;
  endfunction

  // Twiddle word: cosine in the upper half, sine in the lower half.
  function automatic tw_rom_t gen_twiddle();
    tw_rom_t t;
    cs_t     cs;
    for (int i = 0; i < HALF_N; i++) begin
      cs   = angle_cs(64'(i));
      t[i] = {sat16((cs.c + 64'sd16384) >>> 15), sat16((cs.s + 64'sd16384) >>> 15)};
    end
    return t;
  endfunction

  function automatic logic [LOG_N-1:0] bit_rev(input logic [LOG_N-1:0] i);
    logic [LOG_N-1:0] r;
    for (int b = 0; b < LOG_N; b++) r[b] = i[LOG_N-1-b];
    return r;
  endfunction

endpackage

>>> design/sfo_if.sv
// Stream interfaces for the sample input and the flux result.
interface sfo_sample_if;
  import sfo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sfo_flux_if;
  import sfo_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLUX_W-1:0] flux;
  modport source (output valid, output flux, input ready);
  modport sink   (input valid, input flux, output ready);
endinterface

>>> design/spectral_flux_onset.sv
// Top level of the spectral flux onset detector.
// The sample channel takes one signed Q1.15 audio sample per transfer into a
// 1024-entry sample ring. Every hop_length samples (APB register at byte
// address 0) the newest 1024 samples are Hann windowed, transformed by a
// 1024-point radix-2 FFT, and the power of bins 1 to 256 is compared with the
// previous frame; the sum of positive increases leaves on the flux channel.
// The first frame after reset only records its powers and gives no transfer.
// While idle the sample channel is ready, so samples that do not close a hop
// are taken back to back. A sample that closes a hop starts a frame during
// which no sample is taken: windowing, then 5120 butterflies, each read,
// multiplied, added and written back upper then lower in turn on the
// single work memory port pair, and last the power and flux pass. The flux
// result sits in an output register; if the receiver stalls, a later frame
// waits at its end until that register is free. Reset clears the control
// state and the have-previous flag; ring entries not yet written read as
// zero by way of the write position and a wrap flag, so no clearing pass runs.
module spectral_flux_onset
  import sfo_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sfo_sample_if.sink    smp_i,
  sfo_flux_if.source    flux_o,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output logic          pready_o
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_FFT, S_PWR, S_DONE} state_e;
  typedef enum logic [2:0] {PH_RD, PH_MUL, PH_ADD, PH_WU, PH_WV} phase_e;

  localparam hann_rom_t HANN_ROM = gen_hann();
  localparam tw_rom_t   TW_ROM   = gen_twiddle();

  state_e state_q;
  phase_e ph_q;

  logic [HOP_W-1:0]   hop_len_q, hop_cnt_q;
  logic [HOP_W:0]     hop_next;
  logic [RING_AW-1:0] ring_pos_q;
  logic               wrapped_q, have_prev_q;
  logic               in_acc, cfg_wr;

  // Memories.
  logic [SMP_W-1:0]  ring_mem [RING_DEPTH];
  logic [WORD_W-1:0] work_mem [FFT_POINTS];
  logic [PWR_W-1:0]  prev_mem [MAG_BINS];

  // Windowing pipeline.
  logic [LOG_N:0]          ld_cnt_q;
  logic                    ld_issue, ld_v1_q, ld_v2_q;
  logic [LOG_N-1:0]        ld_idx1_q, ld_idx2_q;
  logic [RING_AW-1:0]      ring_ra;
  logic [SMP_W-1:0]        ring_rd_q;
  logic                    ring_ok_q;
  logic [SMP_W-1:0]        hann_q;
  logic signed [SMP_W-1:0] smp_win;
  logic signed [33:0]      win_prod_q;
  logic signed [34:0]      win_rnd;

  // Transform sequencing.
  logic [STAGE_W-1:0] stage_q;
  logic [TW_AW-1:0]   bf_q, bf_mask, bf_j;
  logic [LOG_N-1:0]   bf_u, bf_v, bf_hi;
  logic [TW_AW-1:0]   tw_addr;
  logic [31:0]        tw_q;
  bfly_ctrl_t         bctrl;
  logic [WORD_W-1:0]  bf_sum, bf_diff;

  // Work memory ports.
  logic              rd_en, wr_en;
  logic [LOG_N-1:0]  ra_a, ra_b, wa;
  logic [WORD_W-1:0] wd, rd_a_q, rd_b_q;

  // Power and flux pipeline.
  logic [BIN_AW:0]          pw_cnt_q;
  logic                     pw_issue, pw_v1_q, pw_v2_q, pw_v3_q;
  logic [BIN_AW-1:0]        pw_idx1_q, pw_idx2_q, pw_idx3_q;
  logic [PWR_W-1:0]         prev_rd_q, prev2_q, prev3_q, pwr_q;
  logic [2*DATA_W-1:0]      sq_re_q, sq_im_q;
  logic [2*DATA_W:0]        sq_sum;
  logic signed [DATA_W-1:0] pr_re, pr_im;
  logic [FLUX_W-1:0]        flux_acc_q;
  logic [FLUX_W:0]          flux_sum;
  logic [LOG_N-1:0]         bin_addr;

  logic              out_valid_q;
  logic [FLUX_W-1:0] out_flux_q;
  logic              out_load;

  // Configuration port: one hop_length register, always ready.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_HOP_LENGTH);
  assign prdata_o = (paddr_i[2] == REG_HOP_LENGTH) ? {16'd0, hop_len_q} : 32'd0;

  // Handshakes.
  assign smp_i.ready  = (state_q == S_IDLE);
  assign in_acc       = smp_i.valid && smp_i.ready;
  assign flux_o.valid = out_valid_q;
  assign flux_o.flux  = out_flux_q;
  assign hop_next     = {1'b0, hop_cnt_q} + 17'd1;

  // A finished frame with a predecessor loads the output register once it is free.
  assign out_load = (state_q == S_DONE) && have_prev_q && (!out_valid_q || flux_o.ready);

  // Sample ring: written on each input transfer, read while windowing.
  assign ld_issue = (state_q == S_LOAD) && (ld_cnt_q < (LOG_N+1)'(FFT_POINTS));
  assign ring_ra  = ring_pos_q + RING_AW'(ld_cnt_q[LOG_N-1:0]);

  always_ff @(posedge clk_i) begin
    if (in_acc) ring_mem[ring_pos_q] <= smp_i.sample;
    ring_rd_q <= ring_mem[ring_ra];
    ring_ok_q <= wrapped_q || (ring_ra < ring_pos_q);
    hann_q    <= HANN_ROM[ld_cnt_q[LOG_N-1:0]];
    tw_q      <= TW_ROM[tw_addr];
  end

  // Windowed sample, rounded to the nearest integer.
  assign smp_win = ring_ok_q ? $signed(ring_rd_q) : '0;
  assign win_rnd = 35'(win_prod_q) + 35'sd16384;

  always_ff @(posedge clk_i) begin
    win_prod_q <= 34'(smp_win * $signed({1'b0, hann_q}));
  end

  // Butterfly addressing: insert a zero at the stage bit to find the upper leg.
  assign bf_mask = TW_AW'((10'd1 << stage_q) - 10'd1);
  assign bf_j    = bf_q & bf_mask;
  assign bf_hi   = LOG_N'(bf_q) >> stage_q;
  assign bf_u    = LOG_N'(bf_hi << (stage_q + 4'd1)) | LOG_N'(bf_j);
  assign bf_v    = bf_u | LOG_N'(10'd1 << stage_q);
  assign tw_addr = TW_AW'(bf_j << (STAGE_W'(LOG_N - 1) - stage_q));

  assign bctrl.mul_en = (state_q == S_FFT) && (ph_q == PH_MUL);
  assign bctrl.add_en = (state_q == S_FFT) && (ph_q == PH_ADD);

  sfo_butterfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bctrl),
    .u_i    (rd_a_q),
    .v_i    (rd_b_q),
    .tw_i   (tw_q),
    .sum_o  (bf_sum),
    .diff_o (bf_diff)
  );

  // Work memory port selection.
  assign pw_issue = (state_q == S_PWR) && (pw_cnt_q < (BIN_AW+1)'(MAG_BINS));
  assign bin_addr = LOG_N'(pw_cnt_q) + LOG_N'(1);

  always_comb begin
    rd_en = 1'b0;
    ra_a  = bin_addr;
    ra_b  = bf_v;
    wr_en = 1'b0;
    wa    = bit_rev(ld_idx2_q);
    wd    = {DATA_W'(win_rnd >>> 15), DATA_W'(0)};
    priority if (state_q == S_LOAD) begin
      wr_en = ld_v2_q;
    end else if (state_q == S_FFT) begin
      ra_a = bf_u;
      unique case (ph_q)
        PH_RD: rd_en = 1'b1;
        PH_WU: begin wr_en = 1'b1; wa = bf_u; wd = bf_sum;  end
        PH_WV: begin wr_en = 1'b1; wa = bf_v; wd = bf_diff; end
        default: ;
      endcase
    end else if (state_q == S_PWR) begin
      rd_en = pw_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) work_mem[wa] <= wd;
    if (rd_en) begin
      rd_a_q <= work_mem[ra_a];
      rd_b_q <= work_mem[ra_b];
    end
  end

  // Previous frame powers: read at issue, written back when that bin's new power leaves the pipeline.
  always_ff @(posedge clk_i) begin
    prev_rd_q <= prev_mem[pw_cnt_q[BIN_AW-1:0]];
    if (pw_v3_q) prev_mem[pw_idx3_q] <= pwr_q;
  end

  // Power datapath.
  assign pr_re    = rd_a_q[WORD_W-1:DATA_W];
  assign pr_im    = rd_a_q[DATA_W-1:0];
  assign sq_sum   = (2*DATA_W+1)'(sq_re_q) + (2*DATA_W+1)'(sq_im_q);
  assign flux_sum = {1'b0, flux_acc_q} + (FLUX_W+1)'(pwr_q - prev3_q);

  always_ff @(posedge clk_i) begin
    sq_re_q <= (2*DATA_W)'(pr_re * pr_re);
    sq_im_q <= (2*DATA_W)'(pr_im * pr_im);
    prev2_q <= prev_rd_q;
    pwr_q   <= PWR_W'(sq_sum >> 14);
    prev3_q <= prev2_q;
  end

  // Sequencer, counters and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_RD;
      hop_len_q   <= HOP_RESET;
      hop_cnt_q   <= '0;
      ring_pos_q  <= '0;
      wrapped_q   <= 1'b0;
      have_prev_q <= 1'b0;
      ld_cnt_q    <= '0;
      ld_v1_q     <= 1'b0;
      ld_v2_q     <= 1'b0;
      ld_idx1_q   <= '0;
      ld_idx2_q   <= '0;
      stage_q     <= '0;
      bf_q        <= '0;
      pw_cnt_q    <= '0;
      pw_v1_q     <= 1'b0;
      pw_v2_q     <= 1'b0;
      pw_v3_q     <= 1'b0;
      pw_idx1_q   <= '0;
      pw_idx2_q   <= '0;
      pw_idx3_q   <= '0;
      flux_acc_q  <= '0;
      out_valid_q <= 1'b0;
      out_flux_q  <= '0;
    end else begin
      if (cfg_wr) hop_len_q <= pwdata_i[HOP_W-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_flux_q  <= flux_acc_q;
      end else if (flux_o.ready) begin
        out_valid_q <= 1'b0;
      end

      ld_v1_q   <= ld_issue;
      ld_idx1_q <= ld_cnt_q[LOG_N-1:0];
      ld_v2_q   <= ld_v1_q;
      ld_idx2_q <= ld_idx1_q;

      pw_v1_q   <= pw_issue;
      pw_idx1_q <= pw_cnt_q[BIN_AW-1:0];
      pw_v2_q   <= pw_v1_q;
      pw_idx2_q <= pw_idx1_q;
      pw_v3_q   <= pw_v2_q;
      pw_idx3_q <= pw_idx2_q;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ring_pos_q <= ring_pos_q + RING_AW'(1);
            if (ring_pos_q == RING_AW'(RING_DEPTH - 1)) wrapped_q <= 1'b1;
            if (hop_next >= {1'b0, hop_len_q}) begin
              hop_cnt_q <= '0;
              ld_cnt_q  <= '0;
              state_q   <= S_LOAD;
            end else begin
              hop_cnt_q <= hop_next[HOP_W-1:0];
            end
          end
        end
        S_LOAD: begin
          if (ld_issue) ld_cnt_q <= ld_cnt_q + (LOG_N+1)'(1);
          if (ld_v2_q && (ld_idx2_q == LOG_N'(FFT_POINTS - 1))) begin
            stage_q <= '0;
            bf_q    <= '0;
            ph_q    <= PH_RD;
            state_q <= S_FFT;
          end
        end
        S_FFT: begin
          unique case (ph_q)
            PH_RD:  ph_q <= PH_MUL;
            PH_MUL: ph_q <= PH_ADD;
            PH_ADD: ph_q <= PH_WU;
            PH_WU:  ph_q <= PH_WV;
            PH_WV: begin
              ph_q <= PH_RD;
              if (bf_q == TW_AW'(HALF_N - 1)) begin
                bf_q <= '0;
                if (stage_q == STAGE_W'(LOG_N - 1)) begin
                  pw_cnt_q   <= '0;
                  flux_acc_q <= '0;
                  state_q    <= S_PWR;
                end else begin
                  stage_q <= stage_q + STAGE_W'(1);
                end
              end else begin
                bf_q <= bf_q + TW_AW'(1);
              end
            end
            default: ph_q <= PH_RD;
          endcase
        end
        S_PWR: begin
          if (pw_issue) pw_cnt_q <= pw_cnt_q + (BIN_AW+1)'(1);
          if (pw_v3_q) begin
            if (have_prev_q && (pwr_q > prev3_q)) begin
              flux_acc_q <= (flux_sum > {1'b0, FLUX_MAX}) ? FLUX_MAX : flux_sum[FLUX_W-1:0];
            end
            if (pw_idx3_q == BIN_AW'(MAG_BINS - 1)) state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!have_prev_q) begin
            have_prev_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The ring write position does not move while a frame is being worked on.
  a_pos_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && ($past(state_q) != S_IDLE) |-> $stable(ring_pos_q))
    else $error("ring position moved during a frame");

  // A waiting result is never overwritten by the next frame.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !flux_o.ready |=> out_valid_q && $stable(out_flux_q))
    else $error("pending flux result lost");

  // The first frame after reset gives no result.
  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !have_prev_q |=> !$rose(out_valid_q))
    else $error("result from the first frame");

  // Memory writes during the transform only happen in the two write phases.
  a_fft_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FFT) && wr_en |-> (ph_q == PH_WU) || (ph_q == PH_WV))
    else $error("work memory write outside a write phase");
`endif

endmodule

>>> design/sfo_butterfly.sv
// Radix-2 butterfly datapath: twiddle products, rounding and the add and subtract.
module sfo_butterfly
  import sfo_pkg::*;
(
  input  logic              clk_i,
  input  bfly_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] u_i,
  input  logic [WORD_W-1:0] v_i,
  input  logic [31:0]       tw_i,
  output logic [WORD_W-1:0] sum_o,
  output logic [WORD_W-1:0] diff_o
);

  logic signed [15:0]       c, s;
  logic signed [DATA_W-1:0] vr, vi;
  logic signed [PROD_W-1:0] p_cr_q, p_si_q, p_ci_q, p_sr_q;
  logic signed [DATA_W-1:0] ur_q, ui_q, tr_q, ti_q;
  logic signed [PROD_W:0]   acc_r, acc_i;
  logic signed [DATA_W-1:0] sr, si, dr, di;

  assign c  = tw_i[31:16];
  assign s  = tw_i[15:0];
  assign vr = v_i[WORD_W-1:DATA_W];
  assign vi = v_i[DATA_W-1:0];

  // First step: the four twiddle products, and the upper operand held alongside.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_cr_q <= PROD_W'(c * vr);
      p_si_q <= PROD_W'(s * vi);
      p_ci_q <= PROD_W'(c * vi);
      p_sr_q <= PROD_W'(s * vr);
      ur_q   <= u_i[WORD_W-1:DATA_W];
      ui_q   <= u_i[DATA_W-1:0];
    end
  end

  // Second step: combine the products and round back to Q15 scale.
  assign acc_r = (PROD_W+1)'(p_cr_q) + (PROD_W+1)'(p_si_q) + (PROD_W+1)'(16384);
  assign acc_i = (PROD_W+1)'(p_ci_q) - (PROD_W+1)'(p_sr_q) + (PROD_W+1)'(16384);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add_en) begin
      tr_q <= DATA_W'(acc_r >>> 15);
      ti_q <= DATA_W'(acc_i >>> 15);
    end
  end

  // Butterfly outputs, without scaling.
  assign sr = ur_q + tr_q;
  assign si = ui_q + ti_q;
  assign dr = ur_q - tr_q;
  assign di = ui_q - ti_q;

  assign sum_o  = {sr, si};
  assign diff_o = {dr, di};

endmodule
